// File: sv/sirac_pkg.sv
// Shared types, constants and the digit character table for the radix text converter.
// No dependencies; every other file of the block refers to this package by scoped names.

package sirac_pkg;

  localparam int VALUE_BITS_DEFAULT = 32;
  localparam int STEP_BITS          = 8;
  localparam int RADIX_W            = 5;
  localparam int LENGTH_W           = 6;
  localparam int CHAR_W             = 8;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;
  localparam logic [CHAR_W-1:0]  CHAR_MINUS  = 8'h2d;
  localparam logic [CHAR_W-1:0]  CHAR_NONE   = 8'h00;

  typedef struct packed {
    logic done;
    logic quot_zero;
  } div_stat_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
    logic [CHAR_W-1:0] c;
    case (d)
      4'h0: c = 8'h30;
      4'h1: c = 8'h31;
      4'h2: c = 8'h32;
      4'h3: c = 8'h33;
      4'h4: c = 8'h34;
      4'h5: c = 8'h35;
      4'h6: c = 8'h36;
      4'h7: c = 8'h37;
      4'h8: c = 8'h38;
      4'h9: c = 8'h39;
      4'ha: c = 8'h61;
      4'hb: c = 8'h62;
      4'hc: c = 8'h63;
      4'hd: c = 8'h64;
      4'he: c = 8'h65;
      4'hf: c = 8'h66;
      default: c = CHAR_NONE;
    endcase
    return c;
  endfunction

endpackage

// File: sv/sirac_div_serial.sv
// Digit-serial divider: divides a magnitude by the radix, STEP_BITS quotient bits per cycle.
// Depends on sirac_pkg for widths and the status struct.

module sirac_div_serial #(
  parameter int QW = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           load,
  input  logic [QW-1:0]                  dividend,
  input  logic [sirac_pkg::RADIX_W-1:0]  radix,
  output logic [QW-1:0]                  quotient,
  output logic [3:0]                     remainder,
  output sirac_pkg::div_stat_t           stat
);

  localparam int SB    = sirac_pkg::STEP_BITS;
  localparam int STEPS = QW / SB;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic [QW-1:0]    q;
  logic [QW-1:0]    q_next;
  logic [3:0]       r;
  logic [3:0]       r_next;
  logic [CNT_W-1:0] cnt;
  logic             done;

  // The partial remainder stays below the radix, so each bit step is a 5-bit compare.
  always_comb begin
    logic [4:0]    tmp;
    logic [3:0]    rt;
    logic [SB-1:0] qb;
    rt = r;
    qb = '0;
    for (int i = 0; i < SB; i++) begin
      tmp = {rt, q[QW-1-i]};
      if (tmp >= radix) begin
        tmp = tmp - radix;
        qb[SB-1-i] = 1'b1;
      end
      rt = tmp[3:0];
    end
    r_next = rt;
    q_next = (q << SB) | QW'(qb);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (load) begin
        q   <= dividend;
        r   <= '0;
        cnt <= CNT_W'(STEPS);
      end else if (cnt != '0) begin
        q    <= q_next;
        r    <= r_next;
        cnt  <= cnt - CNT_W'(1);
        done <= (cnt == CNT_W'(1));
      end
    end
  end

  assign quotient       = q;
  assign remainder      = r;
  assign stat.done      = done;
  assign stat.quot_zero = (q == '0);

endmodule

// File: sv/signed_integer_to_radix_ascii_unit.sv
// Signed integer to radix text: each digit takes one pass of the serial divider, then come the
// sign slot and a fetch and a put per digit; QW is VALUE_BITS rounded up to a multiple of eight
// (serial divider). One value at a time, busy high until the last character, a bad radix
// answers at once. The receiver cannot stall. Synchronous active-high reset clears control,
// radix to ten.

module signed_integer_to_radix_ascii_unit #(
  parameter int VALUE_BITS = sirac_pkg::VALUE_BITS_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [VALUE_BITS-1:0]          value,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [sirac_pkg::RADIX_W-1:0]         cfg_data,
  output logic                                  strobe,
  output logic [sirac_pkg::CHAR_W-1:0]          character,
  output logic                                  last,
  output logic [sirac_pkg::LENGTH_W-1:0]        length,
  output logic                                  bad_radix
);

  // The quotient register is padded up to a whole number of divider steps.
  localparam int SB = sirac_pkg::STEP_BITS;
  localparam int QW = ((VALUE_BITS + SB - 1) / SB) * SB;
  // Digit count must hold VALUE_BITS itself; the store address only needs VALUE_BITS - 1.
  localparam int CW = $clog2(VALUE_BITS + 1);
  localparam int AW = $clog2(VALUE_BITS);
  localparam int LW = sirac_pkg::LENGTH_W;

  typedef enum logic [2:0] {
    IDLE,
    DIVIDE,
    SIGN,
    FETCH,
    PUT
  } state_t;

  state_t                        state;
  logic [sirac_pkg::RADIX_W-1:0] radix;
  logic                          neg;
  logic [CW-1:0]                 ndig;
  logic [CW-1:0]                 pos;
  logic                          div_load;
  logic [QW-1:0]                 div_dividend;
  logic [QW-1:0]                 div_quotient;
  logic [3:0]                    div_rem;
  sirac_pkg::div_stat_t          div_stat;

  logic [3:0]                    digit_store [VALUE_BITS];
  logic [3:0]                    rd_data;
  logic [AW-1:0]                 rd_addr;
  logic                          wr_en;

  logic                          radix_bad;
  logic [VALUE_BITS-1:0]         raw;
  logic [VALUE_BITS-1:0]         mag;
  logic [LW:0]                   total;
  logic [LW-1:0]                 len;

  // The radix register is only written between transactions, so ready simply follows idle.
  assign cfg_ready = (state == IDLE);
  assign busy      = (state != IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= sirac_pkg::RADIX_RESET;
    end else if (cfg_valid && cfg_ready) begin
      radix <= cfg_data;
    end
  end

  always_comb begin
    radix_bad = !(radix inside {[sirac_pkg::RADIX_MIN:sirac_pkg::RADIX_MAX]});
  end

  // The magnitude is formed in VALUE_BITS unsigned bits, which holds the most negative
  // value's magnitude exactly.
  assign raw = value;
  assign mag = raw[VALUE_BITS-1] ? (~raw + VALUE_BITS'(1)) : raw;

  // Text length is the digit count plus one for a minus sign, kept to six bits.
  assign total = (LW+1)'(ndig) + (LW+1)'(neg);
  assign len   = total[LW-1:0];

  sirac_div_serial #(
    .QW (QW)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .load      (div_load),
    .dividend  (div_dividend),
    .radix     (radix),
    .quotient  (div_quotient),
    .remainder (div_rem),
    .stat      (div_stat)
  );

  // Digits are stored least significant first as the divider produces them, and read
  // back from the top downwards.
  assign wr_en   = (state == DIVIDE) && div_stat.done;
  assign rd_addr = AW'(pos - CW'(1));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      digit_store[ndig[AW-1:0]] <= div_rem;
    end
    rd_data <= digit_store[rd_addr];
  end

  // Sequencer: a bad radix gets the error result, else start a division per digit until the
  // quotient reaches zero, then send the optional minus sign and the stored digits, a digit per fetch and put.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      strobe   <= 1'b0;
      div_load <= 1'b0;
      neg      <= 1'b0;
      ndig     <= '0;
      pos      <= '0;
    end else begin
      strobe   <= 1'b0;
      div_load <= 1'b0;
      case (state)
        IDLE: begin
          if (start) begin
            if (radix_bad) begin
              strobe    <= 1'b1;
              character <= sirac_pkg::CHAR_NONE;
              last      <= 1'b1;
              length    <= '0;
              bad_radix <= 1'b1;
            end else begin
              neg          <= raw[VALUE_BITS-1];
              ndig         <= '0;
              div_dividend <= QW'(mag);
              div_load     <= 1'b1;
              state        <= DIVIDE;
            end
          end
        end
        DIVIDE: begin
          if (div_stat.done) begin
            ndig <= ndig + CW'(1);
            if (div_stat.quot_zero) begin
              pos   <= ndig + CW'(1);
              state <= SIGN;
            end else begin
              div_dividend <= div_quotient;
              div_load     <= 1'b1;
            end
          end
        end
        SIGN: begin
          if (neg) begin
            strobe    <= 1'b1;
            character <= sirac_pkg::CHAR_MINUS;
            last      <= 1'b0;
            length    <= len;
            bad_radix <= 1'b0;
          end
          state <= FETCH;
        end
        FETCH: begin
          state <= PUT;
        end
        PUT: begin
          strobe    <= 1'b1;
          character <= sirac_pkg::digit_char(rd_data);
          last      <= (pos == CW'(1));
          length    <= len;
          bad_radix <= 1'b0;
          pos       <= pos - CW'(1);
          if (pos == CW'(1)) begin
            state <= IDLE;
          end else begin
            state <= FETCH;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  // An error result always reports an empty text and closes the transaction.
  a_bad_result: assert property (@(posedge clk) disable iff (rst)
    strobe && bad_radix |-> last && (length == '0))
    else $error("radix error result without last or with nonzero length");

  // The final character of a transaction leaves the block ready for the next value.
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    strobe && last |-> !busy)
    else $error("final character shown while still busy");

  // Divider completions only arrive while digits are being collected.
  a_div_phase: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> state == DIVIDE)
    else $error("divider finished outside the digit phase");

  // An accepted value either starts a conversion or produces the error result at once.
  a_accept: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy || (strobe && bad_radix))
    else $error("accepted value was neither converted nor rejected");

endmodule
